// ===== design/lfp_pkg.sv =====
// Package: pool size, codes and item types for the linked list free pool.
`timescale 1ns / 1ps

package lfp_pkg;

	localparam int POOL_NODES = 16;
	localparam int IDX_W      = $clog2(POOL_NODES);
	localparam int LINK_W     = IDX_W + 1;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_NODES);

	localparam int ID_W    = 32;
	localparam int GRADE_W = 32;
	localparam int DATA_W  = ID_W + GRADE_W;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_NOSUCC = 2'd3;

	typedef struct packed {
		logic [1:0]             operation;
		logic                   at_head;
		logic [IDX_W-1:0]       node_index;
		logic signed [ID_W-1:0] item_id;
		logic [GRADE_W-1:0]     item_grade;
	} cmd_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [IDX_W-1:0]       touched_node;
		logic signed [ID_W-1:0] read_id;
		logic [GRADE_W-1:0]     read_grade;
		logic [IDX_W-1:0]       read_next;
		logic                   read_next_valid;
		logic [IDX_W-1:0]       head_index;
		logic                   list_empty;
		logic                   pool_full;
	} res_t;

	function automatic logic is_node(input logic [LINK_W-1:0] p);
		return p < NIL;
	endfunction

endpackage

// ===== design/linked_list_free_pool_top.sv =====
// Linked list over a fixed node pool with a free chain; insert, delete and read.
// Takes one item per clock when not stalled and returns one result item per item
// through an input register, then an update step in which the link registers, the
// list and free heads and the id/grade RAM are updated or read, then the result
// register. The whole link table sits in flip-flops so that every operation reads
// and rewrites its links in that update step. Input stalls only when an item waits
// behind a held result, so a new item can enter while a result waits to be taken.
`timescale 1ns / 1ps

module linked_list_free_pool_top
	import lfp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic              cmd_v_s1;
	cmd_t              cmd_s1;
	logic              res_v_s2;
	res_t              res_s2;
	logic              rd_s2;

	logic [LINK_W-1:0] links_q [POOL_NODES];
	logic [LINK_W-1:0] links_d [POOL_NODES];
	logic [LINK_W-1:0] head_q, head_d;
	logic [LINK_W-1:0] free_q, free_d;

	logic              adv_out, take, commit;
	logic [IDX_W-1:0]  g;
	logic [LINK_W-1:0] lnk_fh, lnk_g, lnk_lh, lnk_lg;
	logic [1:0]        status;
	logic [IDX_W-1:0]  touched;
	logic [IDX_W-1:0]  rnext;
	logic              rvalid, rd_ok, ram_we;
	logic [DATA_W-1:0] ram_q;

	assign adv_out   = !res_v_s2 || !res_stall;
	assign commit    = cmd_v_s1 && adv_out;
	assign cmd_stall = cmd_v_s1 && !adv_out;
	assign take      = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_s1 <= 1'b0;
		end else if (take) begin
			cmd_v_s1 <= 1'b1;
		end else if (commit) begin
			cmd_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
		end
	end

	assign g      = cmd_s1.node_index;
	assign lnk_fh = links_q[free_q[IDX_W-1:0]];
	assign lnk_lh = links_q[head_q[IDX_W-1:0]];
	assign lnk_g  = links_q[g];
	assign lnk_lg = links_q[lnk_g[IDX_W-1:0]];

	always_comb begin
		logic g_ok;
		g_ok    = is_node({1'b0, g});
		links_d = links_q;
		head_d  = head_q;
		free_d  = free_q;
		status  = ST_OK;
		touched = '0;
		rnext   = '0;
		rvalid  = 1'b0;
		rd_ok   = 1'b0;
		ram_we  = 1'b0;
		case (cmd_s1.operation)
			OP_INSERT: begin
				if (!is_node(free_q)) begin
					status = ST_FULL;
				end else if (!cmd_s1.at_head && !g_ok) begin
					status = ST_NOSUCC;
				end else begin
					free_d  = lnk_fh;
					ram_we  = 1'b1;
					touched = free_q[IDX_W-1:0];
					if (cmd_s1.at_head) begin
						links_d[free_q[IDX_W-1:0]] = head_q;
						head_d = free_q;
					end else begin
						// given == new node leaves a self loop, as the C order does
						links_d[free_q[IDX_W-1:0]] = lnk_g;
						links_d[g] = free_q;
					end
				end
			end
			OP_DELETE: begin
				if (!is_node(head_q)) begin
					status = ST_EMPTY;
				end else if (cmd_s1.at_head) begin
					head_d  = lnk_lh;
					links_d[head_q[IDX_W-1:0]] = free_q;
					free_d  = head_q;
					touched = head_q[IDX_W-1:0];
				end else if (!g_ok || !is_node(lnk_g)) begin
					status = ST_NOSUCC;
				end else begin
					links_d[g] = lnk_lg;
					links_d[lnk_g[IDX_W-1:0]] = free_q;
					free_d  = lnk_g;
					touched = lnk_g[IDX_W-1:0];
				end
			end
			OP_READ: begin
				if (g_ok) begin
					rd_ok = 1'b1;
					if (is_node(lnk_g)) begin
						rnext  = lnk_g[IDX_W-1:0];
						rvalid = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_NODES; i++) begin
				links_q[i] <= (i == POOL_NODES - 1) ? NIL : LINK_W'(i + 1);
			end
			head_q <= NIL;
			free_q <= '0;
		end else if (commit) begin
			links_q <= links_d;
			head_q  <= head_d;
			free_q  <= free_d;
		end
	end

	lfp_ram #(
		.WIDTH(DATA_W),
		.DEPTH(POOL_NODES)
	) u_data_ram (
		.clk  (clk),
		.we   (commit && ram_we),
		.waddr(free_q[IDX_W-1:0]),
		.wdata({cmd_s1.item_id, cmd_s1.item_grade}),
		.re   (commit && rd_ok),
		.raddr(g),
		.rdata(ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s2 <= 1'b0;
		end else if (commit) begin
			res_v_s2 <= 1'b1;
		end else if (!res_stall) begin
			res_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rd_s2                  <= rd_ok;
			res_s2.status          <= status;
			res_s2.touched_node    <= touched;
			res_s2.read_id         <= '0;
			res_s2.read_grade      <= '0;
			res_s2.read_next       <= rnext;
			res_s2.read_next_valid <= rvalid;
			res_s2.head_index      <= is_node(head_d) ? head_d[IDX_W-1:0] : '0;
			res_s2.list_empty      <= !is_node(head_d);
			res_s2.pool_full       <= !is_node(free_d);
		end
	end

	// RAM output holds while the result waits: no new read without a commit
	always_comb begin
		res = res_s2;
		if (rd_s2) begin
			res.read_id    = ram_q[DATA_W-1:GRADE_W];
			res.read_grade = ram_q[GRADE_W-1:0];
		end
	end

	assign res_valid = res_v_s2;

endmodule

// ===== design/lfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/lfp_checker.sv =====
// Port-level checker for the linked list free pool, bound to the top level.
`timescale 1ns / 1ps

module lfp_checker
	import lfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result item changed while stalled");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.list_empty |-> res.head_index == '0)
		else $error("empty list with nonzero head index");

	a_fail_touch: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_OK |-> res.touched_node == '0 && !res.read_next_valid)
		else $error("failed operation reports a node");

	a_next_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.read_next_valid |-> res.read_next == '0)
		else $error("read_next set without a successor");

endmodule

bind linked_list_free_pool_top lfp_checker u_lfp_checker (.*);

// ===== tb/pool_list_checker.sv =====
// Checker for the linked list pool: predicts each result item and compares it with the block output.
`timescale 1ns / 1ps

module pool_list_checker
	import lfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  logic                  cmd_stall,
	input  cmd_t                  cmd,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  res_t                  res,
	output int                    errors,
	output int                    exp_count,
	output int                    checked,
	output int                    n_full,
	output int                    n_empty,
	output int                    n_nosucc,
	output logic [POOL_NODES-1:0] linked_mask,
	output logic [POOL_NODES-1:0] written_mask
);

	// shadow copy of the pool
	logic signed [ID_W-1:0] pool_id    [POOL_NODES];
	logic [GRADE_W-1:0]     pool_grade [POOL_NODES];
	logic [LINK_W-1:0]      pool_link  [POOL_NODES];
	logic [LINK_W-1:0]      list_first;
	logic [LINK_W-1:0]      free_first;

	res_t want_q[$];

	task automatic clear_pool();
		for (int k = 0; k < POOL_NODES; k++) begin
			pool_id[k]    = '0;
			pool_grade[k] = '0;
			pool_link[k]  = LINK_W'(k + 1);
		end
		list_first   = NIL;
		free_first   = '0;
		want_q.delete();
		written_mask = '0;
		linked_mask  = '0;
		exp_count    = 0;
		errors       = 0;
		checked      = 0;
		n_full       = 0;
		n_empty      = 0;
		n_nosucc     = 0;
	endtask

	// apply one command to the shadow pool and build the result item it should give
	task automatic apply_cmd(input cmd_t c, output res_t r);
		logic [LINK_W-1:0] given;
		logic [IDX_W-1:0]  gi;
		logic [LINK_W-1:0] slot;
		logic [IDX_W-1:0]  si;
		r = '0;
		gi = c.node_index;
		given = {1'b0, gi};
		case (c.operation)
			OP_INSERT: begin
				if (!(free_first < NIL)) begin
					r.status = ST_FULL;
				end else if (!c.at_head && !(given < NIL)) begin
					r.status = ST_NOSUCC;
				end else begin
					slot = free_first;
					si = slot[IDX_W-1:0];
					free_first = pool_link[si];
					pool_id[si] = c.item_id;
					pool_grade[si] = c.item_grade;
					written_mask[si] = 1'b1;
					if (c.at_head) begin
						pool_link[si] = list_first;
						list_first = slot;
					end else begin
						pool_link[si] = pool_link[gi];
						pool_link[gi] = slot;
					end
					r.touched_node = si;
				end
			end
			OP_DELETE: begin
				// empty list wins over every other check
				if (!(list_first < NIL)) begin
					r.status = ST_EMPTY;
				end else if (c.at_head) begin
					slot = list_first;
					si = slot[IDX_W-1:0];
					list_first = pool_link[si];
					pool_link[si] = free_first;
					free_first = slot;
					r.touched_node = si;
				end else if (!(given < NIL) || !(pool_link[gi] < NIL)) begin
					r.status = ST_NOSUCC;
				end else begin
					slot = pool_link[gi];
					si = slot[IDX_W-1:0];
					pool_link[gi] = pool_link[si];
					pool_link[si] = free_first;
					free_first = slot;
					r.touched_node = si;
				end
			end
			OP_READ: begin
				if (given < NIL) begin
					r.read_id = pool_id[gi];
					r.read_grade = pool_grade[gi];
					if (pool_link[gi] < NIL) begin
						r.read_next = pool_link[gi][IDX_W-1:0];
						r.read_next_valid = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (list_first < NIL)
			r.head_index = list_first[IDX_W-1:0];
		r.list_empty = !(list_first < NIL);
		r.pool_full  = !(free_first < NIL);
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		logic [LINK_W-1:0] walk;
		if (!arst_n) begin
			clear_pool();
		end else begin
			if (res_valid && !res_stall) begin
				if (want_q.size() == 0) begin
					$display("%0t ns: result item with nothing expected, expected none, got %p",
						$time, res);
					errors++;
				end else begin
					want = want_q.pop_front();
					cmp_field("status", 32'(want.status), 32'(res.status));
					cmp_field("touched_node", 32'(want.touched_node), 32'(res.touched_node));
					cmp_field("read_id", want.read_id, res.read_id);
					cmp_field("read_grade", want.read_grade, res.read_grade);
					cmp_field("read_next", 32'(want.read_next), 32'(res.read_next));
					cmp_field("read_next_valid", 32'(want.read_next_valid),
						32'(res.read_next_valid));
					cmp_field("head_index", 32'(want.head_index), 32'(res.head_index));
					cmp_field("list_empty", 32'(want.list_empty), 32'(res.list_empty));
					cmp_field("pool_full", 32'(want.pool_full), 32'(res.pool_full));
					checked++;
					case (want.status)
						ST_FULL:   n_full++;
						ST_EMPTY:  n_empty++;
						ST_NOSUCC: n_nosucc++;
						default: ;
					endcase
				end
			end
			if (cmd_valid && !cmd_stall) begin
				apply_cmd(cmd, want);
				want_q.push_back(want);
			end
			// nodes reachable from the head; bounded in case a stray link made a loop
			linked_mask = '0;
			walk = list_first;
			for (int k = 0; k < POOL_NODES; k++) begin
				if (walk < NIL && !linked_mask[walk[IDX_W-1:0]]) begin
					linked_mask[walk[IDX_W-1:0]] = 1'b1;
					walk = pool_link[walk[IDX_W-1:0]];
				end
			end
			exp_count = want_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top: clock, reset, command and result traffic, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
	import lfp_pkg::*;

	localparam logic [1:0] OP_SPARE   = 2'd3;
	localparam int         IDLE_LIMIT = 2000;
	localparam int         LONG_HOLD  = 80;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	int errors, exp_count, checked, n_full, n_empty, n_nosucc;
	logic [POOL_NODES-1:0] linked_mask, written_mask;

	int unsigned sent_cnt = 0;
	int unsigned idle_cycles = 0;
	int unsigned seg_left = 0;
	logic hold_now = 1'b0;
	logic long_hold_done = 1'b0;
	logic fill_mode = 1'b1;

	linked_list_free_pool_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	pool_list_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd          (cmd),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res),
		.errors       (errors),
		.exp_count    (exp_count),
		.checked      (checked),
		.n_full       (n_full),
		.n_empty      (n_empty),
		.n_nosucc     (n_nosucc),
		.linked_mask  (linked_mask),
		.written_mask (written_mask)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// idle length for either side: mostly none or short, a few long, none in the quiet window
	function automatic int unsigned gap_len();
		if (sent_cnt >= 220 && sent_cnt < 280)
			return 0;
		if ($urandom_range(0, 99) < 60)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// random member of a nonempty node mask
	function automatic logic [IDX_W-1:0] pick_node(input logic [POOL_NODES-1:0] m);
		int unsigned n;
		n = $urandom_range(0, $countones(m) - 1);
		for (int k = 0; k < POOL_NODES; k++) begin
			if (m[k]) begin
				if (n == 0)
					return IDX_W'(k);
				n--;
			end
		end
		return '0;
	endfunction

	function automatic cmd_t mk(input logic [1:0] op, input logic hd, input int unsigned idx,
			input logic [31:0] id, input logic [31:0] grade);
		cmd_t c;
		c.operation  = op;
		c.at_head    = hd;
		c.node_index = IDX_W'(idx);
		c.item_id    = id;
		c.item_grade = grade;
		return c;
	endfunction

	// mostly well-formed traffic on the current list, switching between filling and draining
	function automatic cmd_t rand_cmd();
		cmd_t c;
		int unsigned roll, len;
		c = mk(OP_INSERT, 1'($urandom_range(0, 1)), $urandom_range(0, POOL_NODES - 1),
			rand_word(), rand_word());
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			// noise: any code, any node, list may get mangled
			c.operation = 2'($urandom_range(0, 3));
			if (c.operation == OP_READ) begin
				if (written_mask == '0)
					c.operation = OP_SPARE;
				else if (!written_mask[c.node_index])
					c.node_index = pick_node(written_mask);
			end
			return c;
		end
		len = $countones(linked_mask);
		if (fill_mode ? (len == POOL_NODES) : (len == 0)) begin
			if ($urandom_range(0, 3) == 0)
				fill_mode = !fill_mode;
		end else if ($urandom_range(0, 59) == 0) begin
			fill_mode = !fill_mode;
		end
		roll = $urandom_range(0, 99);
		if (roll < (fill_mode ? 65 : 20)) begin
			c.operation = OP_INSERT;
			c.at_head = (len == 0 || $urandom_range(0, 2) == 0);
			if (!c.at_head)
				c.node_index = pick_node(linked_mask);
		end else if (roll < 85) begin
			c.operation = OP_DELETE;
			if (len != 0) begin
				c.at_head = ($urandom_range(0, 2) == 0);
				if (!c.at_head)
					c.node_index = pick_node(linked_mask);
			end
		end else if (written_mask == '0) begin
			c.operation = OP_INSERT;
			c.at_head = 1'b1;
		end else begin
			c.operation = OP_READ;
			if (linked_mask != '0 && $urandom_range(0, 9) < 7)
				c.node_index = pick_node(linked_mask);
			else
				c.node_index = pick_node(written_mask);
		end
		return c;
	endfunction

	// offer one item, fresh ones built only after the previous item has updated the shadow pool
	task automatic offer(input cmd_t c, input bit fresh);
		int unsigned gap;
		@(negedge clk);
		gap = gap_len();
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (fresh)
			c = rand_cmd();
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		sent_cnt++;
	endtask

	// result side: random stalls, one long hold-off so the block backs up
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (seg_left == 0) begin
				if (!long_hold_done && sent_cnt >= 150) begin
					long_hold_done = 1'b1;
					hold_now = 1'b1;
					seg_left = LONG_HOLD;
				end else if (hold_now) begin
					hold_now = 1'b0;
					seg_left = $urandom_range(1, 6);
				end else begin
					seg_left = gap_len();
					hold_now = (seg_left != 0);
					if (!hold_now)
						seg_left = 1;
				end
			end
			res_stall <= hold_now;
			seg_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty list: delete at head and after a node, then the spare code
		offer(mk(OP_DELETE, 1'b1, 0, 0, 0), 1'b0);
		offer(mk(OP_DELETE, 1'b0, 5, 0, 0), 1'b0);
		offer(mk(OP_SPARE, 1'b1, 15, '1, '1), 1'b0);
		// list 1,0,2 with extreme ids and grades
		offer(mk(OP_INSERT, 1'b1, 15, 32'h8000_0000, 32'h0000_0000), 1'b0);
		offer(mk(OP_INSERT, 1'b1, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF), 1'b0);
		offer(mk(OP_INSERT, 1'b0, 0, 32'hFFFF_FFFF, 32'h3F80_0000), 1'b0);
		offer(mk(OP_READ, 1'b0, 1, 0, 0), 1'b0);
		offer(mk(OP_READ, 1'b1, 2, 0, 0), 1'b0);
		// tail has no successor
		offer(mk(OP_DELETE, 1'b0, 2, 0, 0), 1'b0);
		// fill the pool, then one insert too many
		for (int k = 0; k < POOL_NODES - 3; k++)
			offer(mk(OP_INSERT, 1'b1, k, k, $urandom), 1'b0);
		offer(mk(OP_INSERT, 1'b0, 1, 32'h1234_5678, 32'h4049_0FDB), 1'b0);
		// free node 0 from mid-list, read it back from the free chain, drop the head
		offer(mk(OP_DELETE, 1'b0, 1, 0, 0), 1'b0);
		offer(mk(OP_READ, 1'b0, 0, 0, 0), 1'b0);
		offer(mk(OP_DELETE, 1'b1, 9, 0, 0), 1'b0);

		// sender waits for every result to drain
		@(negedge clk);
		cmd_valid <= 1'b0;
		wait (exp_count == 0);

		repeat (430) begin
			offer('0, 1'b1);
			if (sent_cnt == 300) begin
				@(negedge clk);
				cmd_valid <= 1'b0;
				wait (exp_count == 0);
			end
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		wait (exp_count == 0);
		repeat (8) @(posedge clk);
		$display("Sent %0d commands, checked %0d result items, %0d mismatches.",
			sent_cnt, checked, errors);
		$display("Error statuses seen: pool full %0d, list empty %0d, no successor %0d.",
			n_full, n_empty, n_nosucc);
		if (errors == 0 && exp_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
design/lfp_pkg.sv
design/lfp_ram.sv
design/linked_list_free_pool_top.sv
design/lfp_checker.sv
tb/pool_list_checker.sv
tb/tb.sv
